### design/ssae_pkg.sv
// Shared types, opcodes and constants for the sun-safe attitude error block.
`default_nettype none
package ssae_pkg;

	localparam int VEC_BITS  = 16;
	localparam int RATE_BITS = 32;
	localparam int MIN_BITS  = 15;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_CMD_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CMD_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CMD_Z    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_NORM = 3'd3;

	localparam logic [1:0] ST_UPDATED = 2'd0;
	localparam logic [1:0] ST_HELD    = 2'd1;
	localparam logic [1:0] ST_DEGEN   = 2'd2;

	localparam logic [4:0] OP_NOP    = 5'd0;
	localparam logic [4:0] OP_LOAD   = 5'd1;
	localparam logic [4:0] OP_NSQ    = 5'd2;
	localparam logic [4:0] OP_TEST   = 5'd3;
	localparam logic [4:0] OP_DOT    = 5'd4;
	localparam logic [4:0] OP_CLAMP  = 5'd5;
	localparam logic [4:0] OP_CSQ    = 5'd6;
	localparam logic [4:0] OP_SQRT   = 5'd7;
	localparam logic [4:0] OP_VINIT  = 5'd8;
	localparam logic [4:0] OP_VEC    = 5'd9;
	localparam logic [4:0] OP_TINIT  = 5'd10;
	localparam logic [4:0] OP_TAN    = 5'd11;
	localparam logic [4:0] OP_TDINIT = 5'd12;
	localparam logic [4:0] OP_DIV    = 5'd13;
	localparam logic [4:0] OP_TSET   = 5'd14;
	localparam logic [4:0] OP_CROSS  = 5'd15;
	localparam logic [4:0] OP_SHIFT  = 5'd16;
	localparam logic [4:0] OP_SQ     = 5'd17;
	localparam logic [4:0] OP_SQINIT = 5'd18;
	localparam logic [4:0] OP_LEN    = 5'd19;
	localparam logic [4:0] OP_EMUL   = 5'd20;
	localparam logic [4:0] OP_EDINIT = 5'd21;
	localparam logic [4:0] OP_ESET   = 5'd22;
	localparam logic [4:0] OP_OUT    = 5'd23;

	localparam logic [4:0] LAST_MAC   = 5'd3;
	localparam logic [4:0] LAST_CSQ   = 5'd1;
	localparam logic [4:0] LAST_SQRT  = 5'd31;
	localparam logic [4:0] LAST_CORD  = 5'd23;
	localparam logic [4:0] LAST_DIV   = 5'd16;
	localparam logic [4:0] LAST_CROSS = 5'd6;

	typedef struct packed {
		logic [4:0] op;
		logic [4:0] cnt;
		logic [1:0] lane;
	} ssae_cmd_t;

	typedef struct packed {
		logic big;
		logic len_zero;
	} ssae_stat_t;

	function automatic logic [23:0] atan_q24(input logic [4:0] i);
		logic [23:0] v;
		case (i)
			5'd0:    v = 24'd13176795;
			5'd1:    v = 24'd7778716;
			5'd2:    v = 24'd4110060;
			5'd3:    v = 24'd2086331;
			5'd4:    v = 24'd1047214;
			5'd5:    v = 24'd524117;
			5'd6:    v = 24'd262123;
			5'd7:    v = 24'd131069;
			5'd8:    v = 24'd65536;
			5'd9:    v = 24'd32768;
			5'd10:   v = 24'd16384;
			5'd11:   v = 24'd8192;
			5'd12:   v = 24'd4096;
			5'd13:   v = 24'd2048;
			5'd14:   v = 24'd1024;
			5'd15:   v = 24'd512;
			5'd16:   v = 24'd256;
			5'd17:   v = 24'd128;
			5'd18:   v = 24'd64;
			5'd19:   v = 24'd32;
			5'd20:   v = 24'd16;
			5'd21:   v = 24'd8;
			5'd22:   v = 24'd4;
			5'd23:   v = 24'd2;
			default: v = 24'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### design/ssae_dp.sv
// Datapath: configuration, held state, shared multiplier, square root, CORDIC and divider.
`default_nettype none
module ssae_dp import ssae_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ssae_cmd_t                   cmd,
	output ssae_stat_t                       stat,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [VEC_BITS-1:0]         cfg_data,
	input  wire logic signed [VEC_BITS-1:0]  sun_x,
	input  wire logic signed [VEC_BITS-1:0]  sun_y,
	input  wire logic signed [VEC_BITS-1:0]  sun_z,
	input  wire logic signed [RATE_BITS-1:0] rate_x,
	input  wire logic signed [RATE_BITS-1:0] rate_y,
	input  wire logic signed [RATE_BITS-1:0] rate_z,
	output logic signed [VEC_BITS-1:0]       err_x,
	output logic signed [VEC_BITS-1:0]       err_y,
	output logic signed [VEC_BITS-1:0]       err_z,
	output logic signed [RATE_BITS-1:0]      out_rate_x,
	output logic signed [RATE_BITS-1:0]      out_rate_y,
	output logic signed [RATE_BITS-1:0]      out_rate_z,
	output logic [15:0]                      sun_angle,
	output logic [1:0]                       status
);

	localparam logic signed [65:0] ONE_Q28   = 66'sh0_1000_0000;
	localparam logic [63:0]        ONE_Q56   = 64'h0100_0000_0000_0000;
	localparam logic [63:0]        SQRT_BIT0 = 64'h4000_0000_0000_0000;
	localparam logic signed [31:0] HALF_PI   = 32'sd26353589;
	localparam logic signed [31:0] PI_Q24    = 32'sd52707179;
	localparam logic [16:0]        T_MAX     = 17'd16384;

	logic signed [VEC_BITS-1:0]  cfg_v_q [3];
	logic [MIN_BITS-1:0]         mn_q;
	logic signed [VEC_BITS-1:0]  held_err_q [3];
	logic [15:0]                 held_angle_q;

	logic signed [VEC_BITS-1:0]  s_q [3];
	logic signed [RATE_BITS-1:0] rate_q [3];
	logic signed [65:0]          p_q, acc_q;
	logic signed [29:0]          c_q;
	logic [63:0]                 sq_n_q, sq_res_q, sq_bit_q;
	logic signed [33:0]          x_q, y_q;
	logic signed [31:0]          z_q;
	logic                        tzero_q;
	logic [48:0]                 rem_q, d_q;
	logic [16:0]                 q_q;
	logic [14:0]                 t_q;
	logic signed [33:0]          cr_q [3];
	logic [31:0]                 crm_q [3];
	logic                        crneg_q [3];
	logic [31:0]                 len_q;
	logic [1:0]                  status_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic [29:0]        mn_sq;
	logic [64:0]        sq_sum;
	logic signed [33:0] xs, ys;
	logic signed [31:0] at, zc, ang_r;
	logic               sh;
	logic signed [33:0] crs [3];
	logic [2:0]         cj;
	logic [1:0]         idx;

	assign idx = cmd.cnt[1:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_NSQ: begin
				if (cmd.cnt < LAST_MAC) begin
					mul_a = 33'(s_q[idx]);
					mul_b = 33'(s_q[idx]);
				end
			end
			OP_DOT: begin
				if (cmd.cnt < LAST_MAC) begin
					mul_a = 33'(s_q[idx]);
					mul_b = 33'(cfg_v_q[idx]);
				end
			end
			OP_CSQ: begin
				mul_a = 33'(c_q);
				mul_b = 33'(c_q);
			end
			OP_CROSS: begin
				case (cmd.cnt)
					5'd0: begin mul_a = 33'(s_q[1]); mul_b = 33'(cfg_v_q[2]); end
					5'd1: begin mul_a = 33'(s_q[2]); mul_b = 33'(cfg_v_q[1]); end
					5'd2: begin mul_a = 33'(s_q[2]); mul_b = 33'(cfg_v_q[0]); end
					5'd3: begin mul_a = 33'(s_q[0]); mul_b = 33'(cfg_v_q[2]); end
					5'd4: begin mul_a = 33'(s_q[0]); mul_b = 33'(cfg_v_q[1]); end
					5'd5: begin mul_a = 33'(s_q[1]); mul_b = 33'(cfg_v_q[0]); end
					default: ;
				endcase
			end
			OP_SQ: begin
				if (cmd.cnt < LAST_MAC) begin
					mul_a = $signed({1'b0, crm_q[idx]});
					mul_b = $signed({1'b0, crm_q[idx]});
				end
			end
			OP_EMUL: begin
				mul_a = $signed({1'b0, crm_q[cmd.lane]});
				mul_b = $signed({18'b0, t_q});
			end
			default: ;
		endcase
	end

	assign prod   = mul_a * mul_b;
	assign mn_sq  = {15'b0, mn_q} * {15'b0, mn_q};
	assign sq_sum = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
	assign xs     = x_q >>> cmd.cnt;
	assign ys     = y_q >>> cmd.cnt;
	assign at     = $signed({8'b0, atan_q24(cmd.cnt)});
	assign zc     = (z_q < 32'sd0) ? 32'sd0 : ((z_q > PI_Q24) ? PI_Q24 : z_q);
	assign ang_r  = zc + 32'sd512;
	assign cj     = cmd.cnt[2:0] - 3'd1;

	always_comb begin
		sh = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if (cr_q[k] == 34'sh0_8000_0000 || cr_q[k] == -34'sh0_8000_0000) sh = 1'b1;
		end
		for (int k = 0; k < 3; k++) begin
			crs[k] = sh ? (cr_q[k] >>> 1) : cr_q[k];
		end
	end

	assign stat.big      = acc_q[32:0] > {3'b0, mn_sq};
	assign stat.len_zero = sq_res_q == 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_v_q[0]   <= 16'sd16384;
			cfg_v_q[1]   <= '0;
			cfg_v_q[2]   <= '0;
			mn_q         <= 15'd1638;
			held_err_q[0] <= '0;
			held_err_q[1] <= '0;
			held_err_q[2] <= '0;
			held_angle_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CMD_X:    cfg_v_q[0] <= cfg_data;
					CFG_CMD_Y:    cfg_v_q[1] <= cfg_data;
					CFG_CMD_Z:    cfg_v_q[2] <= cfg_data;
					CFG_MIN_NORM: mn_q <= cfg_data[MIN_BITS-1:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_TINIT) held_angle_q <= ang_r[25:10];
			if (cmd.op == OP_LEN && stat.len_zero) begin
				held_err_q[0] <= '0;
				held_err_q[1] <= '0;
				held_err_q[2] <= '0;
			end
			if (cmd.op == OP_ESET) begin
				held_err_q[cmd.lane] <= crneg_q[cmd.lane] ? -VEC_BITS'(q_q) : VEC_BITS'(q_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		p_q <= prod;
		case (cmd.op)
			OP_LOAD: begin
				s_q[0]    <= sun_x;
				s_q[1]    <= sun_y;
				s_q[2]    <= sun_z;
				rate_q[0] <= rate_x;
				rate_q[1] <= rate_y;
				rate_q[2] <= rate_z;
				acc_q     <= '0;
				status_q  <= ST_UPDATED;
			end
			OP_NSQ, OP_DOT, OP_SQ: begin
				if (cmd.cnt != 5'd0) acc_q <= acc_q + p_q;
			end
			OP_TEST: begin
				acc_q <= '0;
				if (!stat.big) status_q <= ST_HELD;
			end
			OP_CLAMP: begin
				if (acc_q > ONE_Q28) c_q <= 30'(ONE_Q28);
				else if (acc_q < -ONE_Q28) c_q <= 30'(-ONE_Q28);
				else c_q <= acc_q[29:0];
			end
			OP_CSQ: begin
				if (cmd.cnt == LAST_CSQ) begin
					sq_n_q   <= ONE_Q56 - p_q[63:0];
					sq_res_q <= '0;
					sq_bit_q <= SQRT_BIT0;
				end
			end
			OP_SQRT: begin
				if ({1'b0, sq_n_q} >= sq_sum) begin
					sq_n_q   <= sq_n_q - sq_sum[63:0];
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			OP_VINIT: begin
				if (c_q < 30'sd0) begin
					x_q <= $signed({5'b0, sq_res_q[28:0]});
					y_q <= -(34'(c_q));
					z_q <= HALF_PI;
				end else begin
					x_q <= 34'(c_q);
					y_q <= $signed({5'b0, sq_res_q[28:0]});
					z_q <= '0;
				end
			end
			OP_VEC: begin
				if (y_q > 34'sd0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end else if (y_q < 34'sd0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end
			end
			OP_TINIT: begin
				x_q <= 34'sh0_1000_0000;
				y_q <= '0;
				z_q <= zc >>> 2;
			end
			OP_TAN: begin
				if (z_q >= 32'sd0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
			end
			OP_TDINIT: begin
				tzero_q <= (x_q <= 34'sd0) || (y_q <= 34'sd0);
				rem_q   <= {5'b0, y_q[29:0], 14'b0} + {20'b0, x_q[29:1]};
				d_q     <= {x_q[32:0], 16'b0};
				q_q     <= '0;
			end
			OP_DIV: begin
				if (rem_q >= d_q) begin
					rem_q <= rem_q - d_q;
					q_q   <= {q_q[15:0], 1'b1};
				end else begin
					q_q   <= {q_q[15:0], 1'b0};
				end
				d_q <= d_q >> 1;
			end
			OP_TSET: begin
				if (tzero_q) t_q <= '0;
				else if (q_q > T_MAX) t_q <= T_MAX[14:0];
				else t_q <= q_q[14:0];
			end
			OP_CROSS: begin
				if (cmd.cnt != 5'd0) begin
					if (!cj[0]) cr_q[cj[2:1]] <= p_q[33:0];
					else cr_q[cj[2:1]] <= cr_q[cj[2:1]] - p_q[33:0];
				end
			end
			OP_SHIFT: begin
				for (int k = 0; k < 3; k++) begin
					crneg_q[k] <= crs[k] < 34'sd0;
					crm_q[k]   <= 32'((crs[k] < 34'sd0) ? -crs[k] : crs[k]);
				end
				acc_q <= '0;
			end
			OP_SQINIT: begin
				sq_n_q   <= acc_q[63:0];
				sq_res_q <= '0;
				sq_bit_q <= SQRT_BIT0;
			end
			OP_LEN: begin
				len_q <= sq_res_q[31:0];
				if (stat.len_zero) status_q <= ST_DEGEN;
			end
			OP_EDINIT: begin
				rem_q <= {3'b0, p_q[45:0]} + {18'b0, len_q[31:1]};
				d_q   <= {1'b0, len_q, 16'b0};
				q_q   <= '0;
			end
			OP_OUT: begin
				err_x      <= held_err_q[0];
				err_y      <= held_err_q[1];
				err_z      <= held_err_q[2];
				out_rate_x <= rate_q[0];
				out_rate_y <= rate_q[1];
				out_rate_z <= rate_q[2];
				sun_angle  <= held_angle_q;
				status     <= status_q;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### design/ssae_ctrl.sv
// Controller: sequences the datapath and owns the input and output handshakes.
`default_nettype none
module ssae_ctrl import ssae_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire ssae_stat_t stat,
	output ssae_cmd_t       cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_NSQ    = 5'd1;
	localparam logic [4:0] S_TEST   = 5'd2;
	localparam logic [4:0] S_DOT    = 5'd3;
	localparam logic [4:0] S_CLAMP  = 5'd4;
	localparam logic [4:0] S_CSQ    = 5'd5;
	localparam logic [4:0] S_SQRT   = 5'd6;
	localparam logic [4:0] S_VINIT  = 5'd7;
	localparam logic [4:0] S_VEC    = 5'd8;
	localparam logic [4:0] S_TINIT  = 5'd9;
	localparam logic [4:0] S_TAN    = 5'd10;
	localparam logic [4:0] S_TDINIT = 5'd11;
	localparam logic [4:0] S_DIV    = 5'd12;
	localparam logic [4:0] S_TSET   = 5'd13;
	localparam logic [4:0] S_CROSS  = 5'd14;
	localparam logic [4:0] S_SHIFT  = 5'd15;
	localparam logic [4:0] S_SQ     = 5'd16;
	localparam logic [4:0] S_SQINIT = 5'd17;
	localparam logic [4:0] S_LEN    = 5'd18;
	localparam logic [4:0] S_EMUL   = 5'd19;
	localparam logic [4:0] S_EDINIT = 5'd20;
	localparam logic [4:0] S_ESET   = 5'd21;
	localparam logic [4:0] S_OUT    = 5'd22;

	logic [4:0] state_q, state_d, nxt, last;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] lane_q, lane_d;
	logic       pass_q, pass_d;
	logic       adv;

	always_comb begin
		cmd      = '0;
		cmd.cnt  = cnt_q;
		cmd.lane = lane_q;
		in_ready = 1'b0;
		adv      = 1'b1;
		last     = 5'd0;
		nxt      = S_IDLE;
		lane_d   = lane_q;
		pass_d   = pass_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				adv      = in_valid;
				nxt      = S_NSQ;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					pass_d = 1'b0;
					lane_d = 2'd0;
				end
			end
			S_NSQ:    begin cmd.op = OP_NSQ; last = LAST_MAC; nxt = S_TEST; end
			S_TEST:   begin cmd.op = OP_TEST; nxt = stat.big ? S_DOT : S_OUT; end
			S_DOT:    begin cmd.op = OP_DOT; last = LAST_MAC; nxt = S_CLAMP; end
			S_CLAMP:  begin cmd.op = OP_CLAMP; nxt = S_CSQ; end
			S_CSQ:    begin cmd.op = OP_CSQ; last = LAST_CSQ; nxt = S_SQRT; end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				last   = LAST_SQRT;
				nxt    = pass_q ? S_LEN : S_VINIT;
			end
			S_VINIT:  begin cmd.op = OP_VINIT; nxt = S_VEC; end
			S_VEC:    begin cmd.op = OP_VEC; last = LAST_CORD; nxt = S_TINIT; end
			S_TINIT:  begin cmd.op = OP_TINIT; nxt = S_TAN; end
			S_TAN:    begin cmd.op = OP_TAN; last = LAST_CORD; nxt = S_TDINIT; end
			S_TDINIT: begin cmd.op = OP_TDINIT; nxt = S_DIV; end
			S_DIV: begin
				cmd.op = OP_DIV;
				last   = LAST_DIV;
				nxt    = pass_q ? S_ESET : S_TSET;
			end
			S_TSET:   begin cmd.op = OP_TSET; pass_d = 1'b1; nxt = S_CROSS; end
			S_CROSS:  begin cmd.op = OP_CROSS; last = LAST_CROSS; nxt = S_SHIFT; end
			S_SHIFT:  begin cmd.op = OP_SHIFT; nxt = S_SQ; end
			S_SQ:     begin cmd.op = OP_SQ; last = LAST_MAC; nxt = S_SQINIT; end
			S_SQINIT: begin cmd.op = OP_SQINIT; nxt = S_SQRT; end
			S_LEN:    begin cmd.op = OP_LEN; nxt = stat.len_zero ? S_OUT : S_EMUL; end
			S_EMUL:   begin cmd.op = OP_EMUL; nxt = S_EDINIT; end
			S_EDINIT: begin cmd.op = OP_EDINIT; nxt = S_DIV; end
			S_ESET: begin
				cmd.op = OP_ESET;
				if (lane_q == 2'd2) begin
					nxt = S_OUT;
				end else begin
					nxt    = S_EMUL;
					lane_d = lane_q + 2'd1;
				end
			end
			S_OUT: begin
				adv = !out_valid || out_ready;
				if (adv) cmd.op = OP_OUT;
				nxt = S_IDLE;
			end
			default: nxt = S_IDLE;
		endcase
		state_d = state_q;
		cnt_d   = cnt_q;
		if (adv) begin
			if (cnt_q == last) begin
				cnt_d   = 5'd0;
				state_d = nxt;
			end else begin
				cnt_d = cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			lane_q    <= '0;
			pass_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			lane_q  <= lane_d;
			pass_q  <= pass_d;
			if (cmd.op == OP_OUT) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_NSQ && cnt_q == 5'd0))
		else $error("accepted transaction did not start the norm test");

	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		lane_q != 2'd3)
		else $error("error lane out of range");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |-> (!out_valid || out_ready))
		else $error("output register overwritten while stalled");

	a_eset_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ESET || state_q == S_LEN) |-> pass_q)
		else $error("error stage reached before tangent was set");

endmodule
`default_nettype wire

### design/sun_safe_attitude_error.sv
// Top level of the sun-safe attitude error block.
// Usage:
//   Input channel (in_valid/in_ready) takes a measured sun vector and body
//   rate; the output channel (out_valid/out_ready) returns the attitude error
//   MRP, the copied rate, the sun angle and a status code, one result per
//   transaction. The configuration channel (cfg_valid/cfg_ready) writes the
//   commanded sun vector and the minimum norm; it is always ready. The user
//   must see that it is written only while the block is idle; the block itself
//   does not enforce this. An updated error takes the longest path, a
//   degenerate axis a shorter one and a too-small sun vector the shortest.
//   The work consists of the two 32-step square roots, the two 24-step
//   CORDIC passes and four 17-step divisions, all on one sequenced datapath.
//   One transaction is in work at a time; the next is accepted the cycle
//   after the result is loaded into the output register.
//   A stalled receiver holds the result in the output register; the block
//   finishes the current item and waits there.
//   Reset clears the held error and angle and restores the configuration
//   defaults.
`default_nettype none
module sun_safe_attitude_error import ssae_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [VEC_BITS-1:0]  sun_x,
	input  wire logic signed [VEC_BITS-1:0]  sun_y,
	input  wire logic signed [VEC_BITS-1:0]  sun_z,
	input  wire logic signed [RATE_BITS-1:0] rate_x,
	input  wire logic signed [RATE_BITS-1:0] rate_y,
	input  wire logic signed [RATE_BITS-1:0] rate_z,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [VEC_BITS-1:0]       err_x,
	output logic signed [VEC_BITS-1:0]       err_y,
	output logic signed [VEC_BITS-1:0]       err_z,
	output logic signed [RATE_BITS-1:0]      out_rate_x,
	output logic signed [RATE_BITS-1:0]      out_rate_y,
	output logic signed [RATE_BITS-1:0]      out_rate_z,
	output logic [15:0]                      sun_angle,
	output logic [1:0]                       status,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [VEC_BITS-1:0]         cfg_data
);

	ssae_cmd_t  cmd;
	ssae_stat_t stat;

	assign cfg_ready = 1'b1;

	ssae_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ssae_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sun_x      (sun_x),
		.sun_y      (sun_y),
		.sun_z      (sun_z),
		.rate_x     (rate_x),
		.rate_y     (rate_y),
		.rate_z     (rate_z),
		.err_x      (err_x),
		.err_y      (err_y),
		.err_z      (err_z),
		.out_rate_x (out_rate_x),
		.out_rate_y (out_rate_y),
		.out_rate_z (out_rate_z),
		.sun_angle  (sun_angle),
		.status     (status)
	);

endmodule
`default_nettype wire

### test/tb_sun_safe_attitude_error.sv
// Self-checking testbench for the sun-safe attitude error block.
`timescale 1ns / 1ps
module tb_sun_safe_attitude_error;
	import ssae_pkg::*;

	typedef struct packed {
		logic signed [VEC_BITS-1:0]  ex, ey, ez;
		logic signed [RATE_BITS-1:0] rx, ry, rz;
		logic [15:0]                 angle;
		logic [1:0]                  st;
	} att_result_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint PI_Q24      = 52707179;
	localparam longint HALF_PI_Q24 = 26353589;
	localparam longint ONE_Q28     = 64'sd1 <<< 28;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic signed [VEC_BITS-1:0] sun_x, sun_y, sun_z;
	logic signed [RATE_BITS-1:0] rate_x, rate_y, rate_z;
	logic signed [VEC_BITS-1:0] err_x, err_y, err_z;
	logic signed [RATE_BITS-1:0] out_rate_x, out_rate_y, out_rate_z;
	logic [15:0] sun_angle;
	logic [1:0] status;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VEC_BITS-1:0] cfg_data;

	logic signed [VEC_BITS-1:0] cmd_x, cmd_y, cmd_z;
	logic [MIN_BITS-1:0] min_norm;
	logic signed [VEC_BITS-1:0] held_err [3];
	logic [15:0] held_ang;

	att_result_t pending_results[$];
	int errors;
	int idle_cycles;
	int hold_cycles;
	bit stall_enable;

	sun_safe_attitude_error u_dut (.*);

	always #10 clk = ~clk;

	function automatic longint sra(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned sqrt_floor(longint unsigned n);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n) bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	function automatic longint arctab(int i);
		return longint'(atan_q24(5'(i)));
	endfunction

	function automatic longint angle_of_cos(longint c);
		longint mc, sn, x, y, z, nx;
		mc = c < 0 ? -c : c;
		sn = longint'(sqrt_floor((64'd1 << 56) - longint'(mc * mc)));
		x = c; y = sn; z = 0;
		if (c < 0) begin
			x = sn; y = -c; z = HALF_PI_Q24;
		end
		for (int i = 0; i < 24; i++) begin
			if (y > 0) begin
				nx = x + sra(y, i); y = y - sra(x, i); z += arctab(i); x = nx;
			end else if (y < 0) begin
				nx = x - sra(y, i); y = y + sra(x, i); z -= arctab(i); x = nx;
			end
		end
		if (z < 0) z = 0;
		if (z > PI_Q24) z = PI_Q24;
		return z;
	endfunction

	function automatic longint unsigned quarter_tan(longint theta);
		longint x, y, z, nx;
		longint unsigned t;
		x = ONE_Q28; y = 0; z = theta;
		for (int i = 0; i < 24; i++) begin
			if (z >= 0) begin
				nx = x - sra(y, i); y = y + sra(x, i); z -= arctab(i);
			end else begin
				nx = x + sra(y, i); y = y - sra(x, i); z += arctab(i);
			end
			x = nx;
		end
		if (x <= 0 || y <= 0) return 0;
		t = (($unsigned(y) << 14) + ($unsigned(x) >> 1)) / $unsigned(x);
		return t > 16384 ? 16384 : t;
	endfunction

	function automatic att_result_t predict_attitude_error(logic signed [VEC_BITS-1:0] sx,
			logic signed [VEC_BITS-1:0] sy, logic signed [VEC_BITS-1:0] sz,
			logic signed [RATE_BITS-1:0] rx, logic signed [RATE_BITS-1:0] ry,
			logic signed [RATE_BITS-1:0] rz);
		att_result_t r;
		longint s[3], m[3], cr[3];
		longint nsq, mn, dot, c, ang, lim;
		longint unsigned t, umax, sq, len, q, a;
		int sh;
		s[0] = sx; s[1] = sy; s[2] = sz;
		m[0] = cmd_x; m[1] = cmd_y; m[2] = cmd_z;
		nsq = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
		mn = min_norm;
		r.st = ST_HELD;
		if (nsq > mn * mn) begin
			r.st = ST_UPDATED;
			lim = 64'sd1 <<< 61;
			dot = 0;
			for (int k = 0; k < 3; k++) begin
				dot = dot + s[k] * m[k];
				if (dot > lim) dot = lim;
				if (dot < -lim) dot = -lim;
			end
			c = dot > ONE_Q28 ? ONE_Q28 : (dot < -ONE_Q28 ? -ONE_Q28 : dot);
			ang = angle_of_cos(c);
			held_ang = 16'((ang + 512) >> 10);
			t = quarter_tan(ang >>> 2);
			cr[0] = s[1] * m[2] - s[2] * m[1];
			cr[1] = s[2] * m[0] - s[0] * m[2];
			cr[2] = s[0] * m[1] - s[1] * m[0];
			umax = 0;
			for (int k = 0; k < 3; k++) begin
				a = cr[k] < 0 ? -cr[k] : cr[k];
				if (a > umax) umax = a;
			end
			sh = 0;
			while ((umax >> sh) >= (64'd1 << 31)) sh++;
			sq = 0;
			for (int k = 0; k < 3; k++) begin
				cr[k] = sra(cr[k], sh);
				a = cr[k] < 0 ? -cr[k] : cr[k];
				sq += a * a;
			end
			len = sqrt_floor(sq);
			if (len == 0) begin
				r.st = ST_DEGEN;
				for (int k = 0; k < 3; k++) held_err[k] = '0;
			end else begin
				for (int k = 0; k < 3; k++) begin
					a = cr[k] < 0 ? -cr[k] : cr[k];
					q = (a * t + (len >> 1)) / len;
					held_err[k] = cr[k] < 0 ? -VEC_BITS'(q) : VEC_BITS'(q);
				end
			end
		end
		r.ex = held_err[0]; r.ey = held_err[1]; r.ez = held_err[2];
		r.rx = rx; r.ry = ry; r.rz = rz;
		r.angle = held_ang;
		return r;
	endfunction

	function automatic int random_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
		return $urandom_range(0, 4);
	endfunction

	task automatic send_sun_sample(logic signed [VEC_BITS-1:0] sx,
			logic signed [VEC_BITS-1:0] sy, logic signed [VEC_BITS-1:0] sz);
		int gap;
		logic signed [RATE_BITS-1:0] rx, ry, rz;
		gap = stall_enable ? random_gap() : 0;
		rx = $urandom; ry = $urandom; rz = $urandom;
		repeat (gap + 1) @(posedge clk);
		in_valid <= 1'b1;
		sun_x <= sx; sun_y <= sy; sun_z <= sz;
		rate_x <= rx; rate_y <= ry; rate_z <= rz;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(predict_attitude_error(sx, sy, sz, rx, ry, rz));
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VEC_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CMD_X:    cmd_x = val;
			CFG_CMD_Y:    cmd_y = val;
			CFG_CMD_Z:    cmd_z = val;
			CFG_MIN_NORM: min_norm = val[MIN_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_command(logic signed [VEC_BITS-1:0] x, logic signed [VEC_BITS-1:0] y,
			logic signed [VEC_BITS-1:0] z, logic [MIN_BITS-1:0] mn);
		wait_drained();
		write_reg(CFG_CMD_X, x);
		write_reg(CFG_CMD_Y, y);
		write_reg(CFG_CMD_Z, z);
		write_reg(CFG_MIN_NORM, {1'b0, mn});
	endtask

	task automatic random_sun_item();
		logic signed [VEC_BITS-1:0] v[3];
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(0, 5))
				0: v[k] = VEC_BITS'($urandom_range(0, 40) - 20);
				1: v[k] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				2: v[k] = VEC_BITS'($urandom_range(0, 3) - 2
						+ ($urandom_range(0, 1) ? 16384 : -16384));
				default: v[k] = VEC_BITS'($urandom);
			endcase
		end
		if ($urandom_range(0, 9) == 0) begin
			v[0] = cmd_x >>> $urandom_range(0, 1);
			v[1] = cmd_y >>> $urandom_range(0, 1);
			v[2] = cmd_z >>> $urandom_range(0, 1);
			if ($urandom_range(0, 1)) begin
				v[0] = -v[0]; v[1] = -v[1]; v[2] = -v[2];
			end
		end
		send_sun_sample(v[0], v[1], v[2]);
	endtask

	task automatic test_reset_defaults();
		stall_enable = 0;
		send_sun_sample(16384, 0, 0);
		send_sun_sample(0, 16384, 0);
		send_sun_sample(-16384, 0, 0);
		send_sun_sample(0, 0, -16384);
		send_sun_sample(11585, 11585, 0);
		send_sun_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_sun_sample(16'sh8000, 16'sh8000, 16'sh8000);
		send_sun_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
		send_sun_sample(10, 0, 0);
		send_sun_sample(0, 0, 0);
		send_sun_sample(1638, 0, 0);
		send_sun_sample(0, 1639, 0);
		send_sun_sample(-16384, 1, 0);
	endtask

	task automatic test_config_extremes();
		set_command(16'sh4000, 16'sh4000, 16'shc000, 15'h7fff);
		send_sun_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_sun_sample(100, 100, 100);
		set_command(16'shc000, 16'sh0000, 16'sh0000, 0);
		send_sun_sample(1, 0, 0);
		send_sun_sample(0, 0, 1);
		send_sun_sample(0, 0, 0);
		set_command(0, 0, 0, 1);
		send_sun_sample(5000, -3000, 200);
		set_command(9459, 9459, 9459, 500);
		send_sun_sample(9459, 9459, 9459);
		send_sun_sample(-9459, -9459, -9459);
		wait_drained();
		write_reg(CFG_UNUSED, 16'hffff);
		send_sun_sample(1000, 2000, 3000);
	endtask

	task automatic test_random_traffic();
		stall_enable = 1;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_command(16384, 0, 0, 1638);
				1: set_command(0, -16384, 0, 0);
				2: set_command(11585, 0, -11585, MIN_BITS'($urandom_range(0, 20000)));
				3: set_command(VEC_BITS'($urandom), VEC_BITS'($urandom), VEC_BITS'($urandom),
						MIN_BITS'($urandom));
				4: set_command(-9459, 9459, 9459, 15'h7fff);
				default: set_command(0, 0, 16384, 3000);
			endcase
			for (int i = 0; i < 105; i++) random_sun_item();
		end
	endtask

	always @(posedge clk) begin
		att_result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{err_x, err_y, err_z, out_rate_x, out_rate_y, out_rate_z, sun_angle, status};
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result %p", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					$display("%0t mismatch expected %p actual %p", $time, want, got);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || !stall_enable) begin
			out_ready   <= 1'b1;
			hold_cycles <= 0;
		end else if (hold_cycles > 0) begin
			out_ready   <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			out_ready   <= 1'b0;
			hold_cycles <= random_gap();
		end else begin
			out_ready   <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[sun_safe_attitude_error] ERROR");
			$finish;
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		in_valid = 0; cfg_valid = 0;
		sun_x = 0; sun_y = 0; sun_z = 0;
		rate_x = 0; rate_y = 0; rate_z = 0;
		cfg_index = '0; cfg_data = '0;
		errors = 0; idle_cycles = 0; stall_enable = 0;
		cmd_x = 16384; cmd_y = 0; cmd_z = 0; min_norm = 1638;
		held_err[0] = 0; held_err[1] = 0; held_err[2] = 0; held_ang = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_config_extremes();
		test_random_traffic();
		stall_enable = 0;
		wait_drained();
		repeat (300) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("[sun_safe_attitude_error] OK");
		else
			$display("[sun_safe_attitude_error] ERROR");
		$finish;
	end
endmodule
